FILE: hdl/anlp_pkg.sv
// shared types, codes and character helpers for the number literal parser
package anlp_pkg;

	localparam int unsigned MaxLen = 255;

	typedef enum logic [2:0] {
		FMT_NONE = 3'd0,
		FMT_HEX  = 3'd1,
		FMT_BIN  = 3'd2,
		FMT_DEC  = 3'd3,
		FMT_FLT  = 3'd4
	} fmt_t;

	localparam logic [1:0] LN_HEX = 2'd0;
	localparam logic [1:0] LN_BIN = 2'd1;
	localparam logic [1:0] LN_DEC = 2'd2;
	localparam logic [1:0] LN_FLT = 2'd3;

	localparam logic [7:0] IN_BODY   = 8'h20;
	localparam logic [7:0] FLAG_MASK = 8'hDF;
	localparam logic [7:0] BAD_DIGIT = 8'hF0;

	typedef struct packed {
		logic [63:0] value;
		logic [7:0]  digits;
		logic [7:0]  mode;
		logic        sign;
		logic        failed;
	} lane_t;

	// state carried from one character to the next
	typedef struct packed {
		lane_t [3:0] lane;
		logic [63:0] frac_acc;
		logic [7:0]  frac_cnt;
		logic        zero_pend;
		logic [7:0]  char_cnt;
	} pstate_t;

	typedef struct packed {
		logic [2:0]  format;
		logic [63:0] value;
		logic [7:0]  size;
		logic [63:0] frac_value;
		logic [7:0]  frac_digits;
	} result_t;

	function automatic logic [7:0] digit_of(input logic [7:0] c);
		logic [7:0] d;
		if (c >= 8'h30 && c <= 8'h39)
			d = c - 8'h30;
		else if (c >= 8'h41 && c <= 8'h46)
			d = c - 8'h37;
		else if (c >= 8'h61 && c <= 8'h66)
			d = c - 8'h57;
		else
			d = BAD_DIGIT;
		return d;
	endfunction

	function automatic logic [63:0] times_ten_plus(input logic [63:0] v, input logic [7:0] d);
		return (v << 3) + (v << 1) + {56'd0, d};
	endfunction

endpackage

FILE: hdl/anlp_lane.sv
// one recognizer lane: prefix and body handling for a single character
module anlp_lane import anlp_pkg::*; (
	input  logic [1:0]  kind,
	input  logic [7:0]  ch,
	input  logic        force_body,
	input  lane_t       cur,
	input  logic [63:0] frac_acc,
	input  logic [7:0]  frac_cnt,
	output lane_t       nxt,
	output logic [63:0] frac_acc_nxt,
	output logic [7:0]  frac_cnt_nxt,
	output logic        zero_seen
);

	logic [7:0] md;
	logic [7:0] d;
	logic       mark;
	logic [7:0] mode_in;

	always_comb begin
		nxt          = cur;
		frac_acc_nxt = frac_acc;
		frac_cnt_nxt = frac_cnt;
		zero_seen    = 1'b0;
		d            = digit_of(ch);
		mode_in      = cur.mode;
		mark         = 1'b0;
		md           = 8'd0;
		if (!force_body && (cur.mode & IN_BODY) == 8'd0) begin
			if (ch == 8'h20 || ch == 8'h2B) begin
				mode_in = 8'hFF;
			end else if (ch == 8'h2D) begin
				nxt.sign = ~cur.sign;
				mode_in  = 8'hFF;
			end else if (kind == LN_HEX && ch == 8'h24) begin
				nxt.mode = IN_BODY | 8'd1;
				mode_in  = 8'hFF;
			end else if (kind == LN_HEX && ch == 8'h30) begin
				zero_seen = 1'b1;
				mode_in   = 8'hFF;
			end
		end
		// 8'hFF flags that the prefix already consumed the character
		if (mode_in != 8'hFF) begin
			mode_in  = cur.mode | IN_BODY;
			nxt.mode = mode_in;
			md       = mode_in & FLAG_MASK;
			if (!cur.failed) begin
				if (ch == 8'h20) begin
					nxt.mode = mode_in | 8'h80;
				end else begin
					if (kind == LN_HEX)
						mark = (ch == 8'h68 || ch == 8'h48);
					else if (kind == LN_BIN)
						mark = (ch == 8'h62 || ch == 8'h42);
					if (mark) begin
						if (md == 8'd0)
							nxt.mode = IN_BODY | 8'd3;
						else
							nxt.failed = 1'b1;
					end else if (kind == LN_FLT) begin
						if (ch == 8'h66 || ch == 8'h46) begin
							if ((md & 8'h0F) == 8'd0)
								nxt.mode = mode_in | 8'd3;
							else
								nxt.failed = 1'b1;
						end else if (ch == 8'h2E) begin
							if (md == 8'd0)
								nxt.mode = mode_in | 8'h10;
							else
								nxt.failed = 1'b1;
						end else if ((md & 8'h8F) != 8'd0 || d > 8'd9) begin
							nxt.failed = 1'b1;
						end else if ((md & 8'h10) != 8'd0) begin
							frac_acc_nxt = times_ten_plus(frac_acc, d);
							frac_cnt_nxt = frac_cnt + 8'd1;
							nxt.digits   = cur.digits + 8'd1;
						end else begin
							nxt.value  = times_ten_plus(cur.value, d);
							nxt.digits = cur.digits + 8'd1;
						end
					end else if ((md & 8'h80) != 8'd0) begin
						nxt.failed = 1'b1;
					end else if (kind == LN_HEX) begin
						if (d > 8'd15) nxt.failed = 1'b1;
						else begin
							nxt.value  = {cur.value[59:0], d[3:0]};
							nxt.digits = cur.digits + 8'd1;
						end
					end else if (kind == LN_BIN) begin
						if (d > 8'd1) nxt.failed = 1'b1;
						else begin
							nxt.value  = {cur.value[62:0], d[0]};
							nxt.digits = cur.digits + 8'd1;
						end
					end else begin
						if (d > 8'd9) nxt.failed = 1'b1;
						else begin
							nxt.value  = times_ten_plus(cur.value, d);
							nxt.digits = cur.digits + 8'd1;
						end
					end
				end
			end
		end
	end

endmodule

FILE: hdl/anlp_step.sv
// next-state and result logic for one character across all four lanes
module anlp_step import anlp_pkg::*; (
	input  pstate_t    cur,
	input  logic [7:0] ch,
	input  logic       is_last,
	output pstate_t    nxt,
	output logic       emit,
	output result_t    res
);

	logic    take;
	logic    zp_c;
	lane_t   hx_a, hx_b, hx_c, hx_p, hx_e, hx_lo;
	lane_t   bn_n, dc_n, fl_n;
	logic [63:0] fa_f;
	logic [7:0]  fc_f;
	pstate_t s1;
	logic [7:0] sz_h, sz_d;

	// hex path when a pending leading zero resolves to a digit
	anlp_lane u_hz0 (.kind(LN_HEX), .ch(8'h30), .force_body(1'b1), .cur(cur.lane[LN_HEX]),
		.frac_acc(cur.frac_acc), .frac_cnt(cur.frac_cnt), .nxt(hx_a),
		.frac_acc_nxt(), .frac_cnt_nxt(), .zero_seen());
	anlp_lane u_hz1 (.kind(LN_HEX), .ch(ch), .force_body(1'b1), .cur(hx_a),
		.frac_acc(cur.frac_acc), .frac_cnt(cur.frac_cnt), .nxt(hx_b),
		.frac_acc_nxt(), .frac_cnt_nxt(), .zero_seen());
	anlp_lane u_hx (.kind(LN_HEX), .ch(ch), .force_body(1'b0), .cur(cur.lane[LN_HEX]),
		.frac_acc(cur.frac_acc), .frac_cnt(cur.frac_cnt), .nxt(hx_c),
		.frac_acc_nxt(), .frac_cnt_nxt(), .zero_seen(zp_c));
	anlp_lane u_bn (.kind(LN_BIN), .ch(ch), .force_body(1'b0), .cur(cur.lane[LN_BIN]),
		.frac_acc(cur.frac_acc), .frac_cnt(cur.frac_cnt), .nxt(bn_n),
		.frac_acc_nxt(), .frac_cnt_nxt(), .zero_seen());
	anlp_lane u_dc (.kind(LN_DEC), .ch(ch), .force_body(1'b0), .cur(cur.lane[LN_DEC]),
		.frac_acc(cur.frac_acc), .frac_cnt(cur.frac_cnt), .nxt(dc_n),
		.frac_acc_nxt(), .frac_cnt_nxt(), .zero_seen());
	anlp_lane u_fl (.kind(LN_FLT), .ch(ch), .force_body(1'b0), .cur(cur.lane[LN_FLT]),
		.frac_acc(cur.frac_acc), .frac_cnt(cur.frac_cnt), .nxt(fl_n),
		.frac_acc_nxt(fa_f), .frac_cnt_nxt(fc_f), .zero_seen());

	// end of string with a zero still pending: it counts as a hex digit
	anlp_lane u_he (.kind(LN_HEX), .ch(8'h30), .force_body(1'b1), .cur(hx_p),
		.frac_acc(cur.frac_acc), .frac_cnt(cur.frac_cnt), .nxt(hx_e),
		.frac_acc_nxt(), .frac_cnt_nxt(), .zero_seen());

	assign take = (ch != 8'd0) && (cur.char_cnt < 8'(MaxLen));
	assign emit = (ch == 8'd0) || is_last;

	always_comb begin
		s1 = cur;
		if (take) begin
			s1.zero_pend = 1'b0;
			if (cur.zero_pend) begin
				if (ch == 8'h78) begin
					s1.lane[LN_HEX]      = cur.lane[LN_HEX];
					s1.lane[LN_HEX].mode = IN_BODY | 8'd2;
				end else begin
					s1.lane[LN_HEX] = hx_b;
				end
			end else begin
				s1.lane[LN_HEX] = hx_c;
				s1.zero_pend    = zp_c;
			end
			s1.lane[LN_BIN] = bn_n;
			s1.lane[LN_DEC] = dc_n;
			s1.lane[LN_FLT] = fl_n;
			s1.frac_acc     = fa_f;
			s1.frac_cnt     = fc_f;
			s1.char_cnt     = cur.char_cnt + 8'd1;
		end
	end

	assign hx_p  = s1.lane[LN_HEX];
	assign hx_lo = s1.zero_pend ? hx_e : hx_p;
	assign sz_h  = {hx_lo.digits[5:0], 2'b00};
	assign sz_d  = {s1.lane[LN_DEC].digits[5:0], 2'b00};

	always_comb begin
		res = '0;
		if (!hx_lo.failed && hx_lo.digits != 8'd0 && (hx_lo.mode & 8'h5F) != 8'd0
				&& sz_h != 8'd0) begin
			res.format = FMT_HEX;
			res.value  = hx_lo.sign ? 64'd0 - hx_lo.value : hx_lo.value;
			res.size   = sz_h;
		end else if (!s1.lane[LN_BIN].failed && s1.lane[LN_BIN].digits != 8'd0
				&& (s1.lane[LN_BIN].mode & 8'h5F) != 8'd0) begin
			res.format = FMT_BIN;
			res.value  = s1.lane[LN_BIN].sign ? 64'd0 - s1.lane[LN_BIN].value
				: s1.lane[LN_BIN].value;
			res.size   = s1.lane[LN_BIN].digits;
		end else if (!s1.lane[LN_DEC].failed && s1.lane[LN_DEC].digits != 8'd0
				&& sz_d != 8'd0) begin
			res.format = FMT_DEC;
			res.value  = s1.lane[LN_DEC].sign ? 64'd0 - s1.lane[LN_DEC].value
				: s1.lane[LN_DEC].value;
			res.size   = sz_d;
		end else if (!s1.lane[LN_FLT].failed && s1.lane[LN_FLT].digits != 8'd0
				&& (s1.lane[LN_FLT].mode & 8'h1F) != 8'd0) begin
			res.format      = FMT_FLT;
			res.value       = s1.lane[LN_FLT].sign ? 64'd0 - s1.lane[LN_FLT].value
				: s1.lane[LN_FLT].value;
			res.size        = s1.lane[LN_FLT].digits;
			res.frac_value  = s1.lane[LN_FLT].sign ? 64'd0 - s1.frac_acc : s1.frac_acc;
			res.frac_digits = s1.frac_cnt;
		end
		nxt = emit ? '0 : s1;
	end

endmodule

FILE: hdl/ascii_number_literal_parser_unit.sv
// top level: input register, per-character step logic and result register
//
//  channel | dir | tdata                                   | tlast | tuser
//  s_axis  | in  | char_in[7:0]                            | last  | -
//  m_axis  | out | format,value,size,frac_value,frac_digits | -     | -
//
// one character per cycle while the result side is not stalled; the last character of a string
// passes through the input register and then the result register to its result beat
// arst_n clears all parser state and both valid flags
// a stalled result holds the result register; the input register moves on unless its
// beat ends a string while the result register is full and stalled
module ascii_number_literal_parser_unit import anlp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,  // char_in[7:0]
	input  logic         s_axis_tlast,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [151:0] m_axis_tdata   // format[2:0], value[66:3], size[74:67],
	                                    // frac_value[138:75], frac_digits[146:139]
);

	logic       vld_s1;
	logic [7:0] ch_s1;
	logic       last_s1;
	pstate_t    st_q, st_nxt;
	logic       emit;
	result_t    res;
	logic       out_vld_q;
	result_t    out_q;
	logic       adv;

	anlp_step u_step (.cur(st_q), .ch(ch_s1), .is_last(last_s1), .nxt(st_nxt),
		.emit(emit), .res(res));

	// stage 1 may advance unless it would emit into a full, stalled result register
	assign adv           = !(vld_s1 && emit && out_vld_q && !m_axis_tready);
	assign s_axis_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			st_q      <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (adv) begin
				vld_s1 <= s_axis_tvalid;
				if (vld_s1) st_q <= st_nxt;
			end
			if (adv && vld_s1 && emit) out_vld_q <= 1'b1;
			else if (m_axis_tready) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ch_s1   <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
			if (vld_s1 && emit) out_q <= res;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {5'd0, out_q.frac_digits, out_q.frac_value, out_q.size,
		out_q.value, out_q.format};

`ifndef SYNTHESIS
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result lost");
	a_fmt_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[2:0] <= 3'd4) else $error("bad format");
	a_frac_only_float: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2:0] != 3'd4 |-> m_axis_tdata[146:75] == '0)
		else $error("fraction on non-float");
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.char_cnt <= 8'(MaxLen)) else $error("char count overrun");
`endif

endmodule
